// ----- rtl/lr_pkg.sv -----
// shared types and constants for the line rasterizer
// no dependencies; imported by lr_setup and line_rasterizer_top
`timescale 1ns / 1ps

package lr_pkg;

	localparam int COORD_BITS = 12;
	localparam int DELTA_W    = COORD_BITS + 1;
	localparam int STR_W      = COORD_BITS + 2;
	localparam int DIAG_W     = COORD_BITS + 3;
	localparam int DEC_W      = COORD_BITS + 4;
	localparam int STEP_W     = 4;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_STEP = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [STEP_W-1:0] step_t;

	typedef struct packed {
		logic   kind;
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
	} in_item_t;

	typedef struct packed {
		coord_t pixel_x;
		coord_t pixel_y;
		logic   last_pixel;
	} out_item_t;

	// running state of the line being drawn
	typedef struct packed {
		coord_t                     cur_x;
		coord_t                     cur_y;
		coord_t                     major_end;
		logic signed [DEC_W-1:0]    decision;
		logic [STR_W-1:0]           incr_straight;
		logic signed [DIAG_W-1:0]   incr_diagonal;
		logic                       major_is_y;
		logic                       minor_negative;
		logic                       active;
	} lr_line_t;

endpackage

// ----- rtl/lr_setup.sv -----
// line setup: axis choice, endpoint ordering and decision terms for a load item
// depends on lr_pkg
`timescale 1ns / 1ps

module lr_setup
	import lr_pkg::*;
(
	input  in_item_t item,
	output lr_line_t line
);

	logic signed [DELTA_W-1:0] dx, dy;
	logic [COORD_BITS-1:0]     adx, ady;
	logic                      major_y, swap;
	logic [COORD_BITS-1:0]     dmaj, dmin;

	always_comb begin
		dx  = {item.end_x[COORD_BITS-1], item.end_x} - {item.start_x[COORD_BITS-1], item.start_x};
		dy  = {item.end_y[COORD_BITS-1], item.end_y} - {item.start_y[COORD_BITS-1], item.start_y};
		adx = dx[DELTA_W-1] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
		ady = dy[DELTA_W-1] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
		major_y = !(ady < adx);
		// endpoints swap when the major coordinate falls
		swap = major_y ? dy[DELTA_W-1] : dx[DELTA_W-1];
		dmaj = major_y ? ady : adx;
		dmin = major_y ? adx : ady;

		line.major_is_y = major_y;
		if (major_y) begin
			line.minor_negative = swap ? (dx > 0) : dx[DELTA_W-1];
			line.major_end      = swap ? item.start_y : item.end_y;
		end else begin
			line.minor_negative = swap ? (dy > 0) : dy[DELTA_W-1];
			line.major_end      = swap ? item.start_x : item.end_x;
		end
		line.cur_x = swap ? item.end_x : item.start_x;
		line.cur_y = swap ? item.end_y : item.start_y;

		line.incr_straight = {1'b0, dmin, 1'b0};
		line.incr_diagonal = $signed({2'b00, dmin, 1'b0}) - $signed({2'b00, dmaj, 1'b0});
		line.decision      = $signed({3'b000, dmin, 1'b0}) - $signed({4'b0000, dmaj});
		line.active        = (dmaj != '0);
	end

endmodule

// ----- rtl/line_rasterizer_top.sv -----
// midpoint line rasterizer top level: input stage, line state, step logic, result register
// depends on lr_pkg and lr_setup
`timescale 1ns / 1ps

// Usage
// in channel (in_valid/in_ready/in_data): a load item (kind = 0) sets up a new line from its
// two endpoints and replaces any line in progress; a step item (kind = 1) advances the line
// by one step and yields one pixel, with last_pixel set on the final one. The start pixel
// is never produced, and a step with no line in progress or a zero-length load yields nothing.
// cfg channel (cfg_valid/cfg_ready/cfg_data): step size in pixels, 0 acts as 1. It is always
// ready and should be written only while no item is in flight.
// out channel (out_valid/out_ready/out_data): one pixel per producing step item.
// Each item waits in the input register; a producing step then writes its pixel to the result register.
// Throughput: one item per cycle while the output is not stalled; the line state is updated in the same cycle an item
// leaves the input register, so a step may directly follow a load.
// Reset: no line in progress, step size 1, both stages empty.
// Stall: the result register holds while out_ready is low; a producing step waits in the
// input register and in_ready drops once that register is full and blocked.

module line_rasterizer_top
	import lr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  step_t     cfg_data
);

	in_item_t  item_s1;
	logic      valid_s1;
	lr_line_t  line_q;
	step_t     step_size_q;
	out_item_t out_data_q;
	logic      out_valid_q;

	lr_line_t  load_line, step_line, line_next;
	logic      produce, fire, out_free;

	step_t                     step_amt;
	coord_t                    step_c, maj, mino, mino_next;
	logic signed [DELTA_W-1:0] nmaj;
	logic                      step_last, diag_take;
	logic signed [DEC_W-1:0]   dec_str, dec_diag;

	lr_setup u_setup (
		.item (item_s1),
		.line (load_line)
	);

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign produce   = (item_s1.kind == KIND_STEP) && line_q.active;
	assign fire      = valid_s1 && (!produce || out_free);
	assign in_ready  = !valid_s1 || fire;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// one step along the major axis
	always_comb begin
		step_amt  = (step_size_q == '0) ? STEP_W'(1) : step_size_q;
		step_c    = {{(COORD_BITS-STEP_W){1'b0}}, step_amt};
		maj       = line_q.major_is_y ? line_q.cur_y : line_q.cur_x;
		mino      = line_q.major_is_y ? line_q.cur_x : line_q.cur_y;
		nmaj      = $signed({maj[COORD_BITS-1], maj})
			+ $signed({{(DELTA_W-STEP_W){1'b0}}, step_amt});
		step_last = nmaj >= $signed({line_q.major_end[COORD_BITS-1], line_q.major_end});
		dec_str   = {{(DEC_W-STR_W){1'b0}}, line_q.incr_straight};
		dec_diag  = {{(DEC_W-DIAG_W){line_q.incr_diagonal[DIAG_W-1]}}, line_q.incr_diagonal};
		diag_take = line_q.decision > 0;
		if (!diag_take)
			mino_next = mino;
		else if (line_q.minor_negative)
			mino_next = mino - step_c;
		else
			mino_next = mino + step_c;

		step_line          = line_q;
		step_line.decision = line_q.decision + (diag_take ? dec_diag : dec_str);
		step_line.active   = !step_last;
		if (line_q.major_is_y) begin
			step_line.cur_y = nmaj[COORD_BITS-1:0];
			step_line.cur_x = mino_next;
		end else begin
			step_line.cur_x = nmaj[COORD_BITS-1:0];
			step_line.cur_y = mino_next;
		end

		if (item_s1.kind == KIND_LOAD)
			line_next = load_line;
		else
			line_next = step_line;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			line_q      <= '0;
			step_size_q <= STEP_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (cfg_valid && cfg_ready)
				step_size_q <= cfg_data;
			if (fire && (item_s1.kind == KIND_LOAD || produce))
				line_q <= line_next;
			if (fire && produce)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			item_s1 <= in_data;
		if (fire && produce) begin
			out_data_q.pixel_x    <= step_line.cur_x;
			out_data_q.pixel_y    <= step_line.cur_y;
			out_data_q.last_pixel <= step_last;
		end
	end

	// the decision term stays between the two increments while a line is in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		line_q.active |-> (line_q.decision > dec_diag) && (line_q.decision <= dec_str))
		else $error("decision term out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && produce && step_last) |=> !line_q.active)
		else $error("line still active after last pixel");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(fire && produce))
		else $error("result appeared without a producing step");

	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && produce && !out_free))
		else $error("input stalled without a blocked step");

endmodule
